// ===== rtl/scd_pkg.sv =====
// Shared types, codes and constants for the sample clock discipline block.
// Used by scd_dp, scd_ctrl, the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package scd_pkg;

	// Time format default: fractional bits of a second
	localparam int TIME_FRAC_BITS_DEF = 32;

	// Shared divider geometry
	localparam int DIV_NUM_W = 128;
	localparam int DIV_DEN_W = 84;
	localparam int DIV_Q_W   = 64;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [19:0] NOMINAL_RST = 20'd48000;
	localparam logic [15:0] BLOCK_RST   = 16'd1024;
	localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
	localparam logic [2:0]  SKIP_LIMIT  = 3'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NOMINAL = 2'd0,
		CFG_BLOCK   = 2'd1,
		CFG_SKIP    = 2'd2,
		CFG_PRESET  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_RESTART = 2'd0,
		PH_PRERUN  = 2'd1,
		PH_SETUP   = 2'd2,
		PH_RUN     = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		CAUSE_NONE   = 2'd0,
		CAUSE_RATE   = 2'd1,
		CAUSE_DRIFT  = 2'd2,
		CAUSE_OFFSET = 2'd3
	} cause_t;

	// Datapath operations issued by the controller
	typedef enum logic [5:0] {
		OP_NOP,
		OP_LOAD,
		OP_BUF_ADD,
		OP_RESTART,
		OP_MUL_ELO,
		OP_MUL_EHI,
		OP_ADD_EL,
		OP_DIV_PRE,
		OP_PRE_FIN,
		OP_MUL_FN,
		OP_DIV_EXP,
		OP_EXP_FIN,
		OP_DIV_ERR,
		OP_ERR_FIN,
		OP_MUL_EB,
		OP_MUL_GAIN,
		OP_DEFER,
		OP_GAIN_LO,
		OP_GAIN_HI,
		OP_GAIN_FIN,
		OP_SETUP_FIN,
		OP_RUN_UPD,
		OP_OFFSET,
		OP_DIV_LIM,
		OP_LIM_FIN,
		OP_DIV_D,
		OP_D_FIN,
		OP_DIV_SLEW,
		OP_RUN_FIN,
		OP_BLK_PREP,
		OP_DIV_BLK,
		OP_BLK_FIN,
		OP_PUBLISH
	} dp_op_t;

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_BUF_ADD,
		ST_CHECK,
		ST_RESTART,
		ST_MUL_ELO,
		ST_MUL_EHI,
		ST_ADD_EL,
		ST_DIV_PRE,
		ST_PRE_FIN,
		ST_MUL_FN,
		ST_DIV_EXP,
		ST_EXP_FIN,
		ST_DIV_ERR,
		ST_ERR_FIN,
		ST_MUL_EB,
		ST_MUL_GAIN,
		ST_DEF_CHK,
		ST_DEFER,
		ST_GAIN_LO,
		ST_GAIN_HI,
		ST_GAIN_FIN,
		ST_SETUP_FIN,
		ST_RUN_UPD,
		ST_OFFSET,
		ST_DIV_LIM,
		ST_LIM_FIN,
		ST_DIV_D,
		ST_D_FIN,
		ST_DIV_SLEW,
		ST_RUN_FIN,
		ST_BLK_PREP,
		ST_DIV_BLK,
		ST_BLK_FIN,
		ST_WAIT,
		ST_PUB
	} state_t;

	typedef struct packed {
		dp_op_t op;
		logic   div_start;
	} cmd_t;

	typedef struct packed {
		logic   blk_op;
		phase_t phase;
		logic   skip;
		logic   prerun_go;
		logic   loop_go;
		logic   defer_go;
		logic   div_done;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/scd_if.sv =====
// Valid/ready channel interfaces for request and result transactions.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface scd_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [15:0] frame_count;
	logic [63:0] now_time;
	logic        force_restart;

	modport source (output valid, output operation, output frame_count, output now_time,
		output force_restart, input ready);
	modport sink (input valid, input operation, input frame_count, input now_time,
		input force_restart, output ready);
endinterface

interface scd_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         phase;
	logic [31:0]        rate_factor;
	logic signed [31:0] slew_step;
	logic [1:0]         reset_cause;
	logic               restart_output;
	logic [63:0]        block_time;
	logic               block_valid;

	modport source (output valid, output phase, output rate_factor, output slew_step,
		output reset_cause, output restart_output, output block_time, output block_valid,
		input ready);
	modport sink (input valid, input phase, input rate_factor, input slew_step,
		input reset_cause, input restart_output, input block_time, input block_valid,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/scd_div.sv =====
// Restoring divider, one quotient bit per cycle, saturating quotient.
// Standalone; used by scd_dp.
`timescale 1ns / 1ps
`default_nettype none

module scd_div #(
	parameter int NUM_W = 128,
	parameter int DEN_W = 84,
	parameter int Q_W   = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  last,
	output logic [Q_W-1:0]        q
);

	localparam int CW = $clog2(NUM_W);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [Q_W-1:0]   quo_q;
	logic             ovf_q;
	logic             dz_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;

	logic [DEN_W:0] rem_sh;
	logic [DEN_W:0] rem_sub;
	logic           ge;

	// One trial subtraction per cycle
	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign last    = busy_q && (cnt_q == CW'(NUM_W - 1));
	assign q       = (ovf_q || dz_q) ? '1 : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
			dz_q  <= (den == '0);
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], ge};
			// a bit pushed out the top means the quotient is too wide
			ovf_q <= ovf_q | quo_q[Q_W-1];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/scd_dp.sv =====
// Datapath: configuration, loop state, multiplier, shared divider, result registers.
// Depends on scd_pkg and scd_div; driven by scd_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module scd_dp
	import scd_pkg::*;
#(
	parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cmd_t                  cmd,
	output sts_t                       sts,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_operation,
	input  wire logic [15:0]           in_frame_count,
	input  wire logic [63:0]           in_now_time,
	input  wire logic                  in_force_restart,
	output logic [1:0]                 out_phase,
	output logic [31:0]                out_rate_factor,
	output logic signed [31:0]         out_slew_step,
	output logic [1:0]                 out_reset_cause,
	output logic                       out_restart_output,
	output logic [63:0]                out_block_time,
	output logic                       out_block_valid
);

	localparam int          SH      = 30 + TIME_FRAC_BITS;
	localparam logic [63:0] OFF_LIM = (64'd1 << TIME_FRAC_BITS) / 64'd50;
	localparam logic [49:0] M4_T1   = 50'd1 << 30;
	localparam logic [49:0] M4_T5   = 50'd5 << 30;
	localparam logic [49:0] M4_T10  = 50'd10 << 30;
	localparam logic [49:0] M4_BAD  = 50'd200 << 30;
	// ceil(2^36 / 5): gain delta is (num >> 32) / 5, exact for 34-bit operands
	localparam logic [33:0] RECIP5    = 34'h3_3333_3334;
	localparam logic [17:0] RECIP5_LO = RECIP5[17:0];
	localparam logic [15:0] RECIP5_HI = RECIP5[33:18];

	// configuration
	logic [19:0] nom_q;
	logic [15:0] bsz_q;
	logic        skip_q;
	logic [63:0] preset_q;

	// loop state
	phase_t             phase_q;
	logic [31:0]        factor_q;
	logic [63:0]        ref_q;
	logic [31:0]        fsr_q;
	logic [63:0]        tb_q;
	logic [63:0]        fat_q;
	logic [63:0]        of_q;
	logic signed [31:0] slew_q;
	logic signed [4:0]  score_q;
	logic [2:0]         defer_q;

	// latched transaction
	logic        op_q;
	logic [15:0] fc_q;
	logic [63:0] now_q;
	logic        frc_q;

	// working registers
	logic [63:0]          prod_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [63:0]          actual_q;
	logic [63:0]          expect_q;
	logic [63:0]          mag_q;
	logic                 eneg_q;
	logic                 oneg_q;
	logic [31:0]          emag_q;
	logic [49:0]          m4_q;
	logic [30:0]          lim_q;
	logic [23:0]          d_q;
	logic [51:0]          glo_q;
	logic [31:0]          gdelta_q;

	// result of the current transaction
	cause_t      cause_q;
	logic        cleared_q;
	logic [63:0] btime_q;
	logic        bvalid_q;

	// divider
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic                 div_last;
	logic [DIV_Q_W-1:0]   div_q;

	scd_div #(
		.NUM_W (DIV_NUM_W),
		.DEN_W (DIV_DEN_W),
		.Q_W   (DIV_Q_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.last   (div_last),
		.q      (div_q)
	);

	// derived values
	logic [63:0] elapsed;
	logic [63:0] off;
	logic [63:0] fd;
	logic [23:0] ten_nom;
	logic [24:0] twenty_nom;
	logic [65:0] gain_num;
	logic [33:0] gain_x;
	logic [67:0] gain_prod;
	logic [63:0] base_time;

	assign elapsed    = now_q - ref_q;
	assign off        = tb_q - ref_q;
	assign fd         = of_q - fat_q;
	assign ten_nom    = 24'({nom_q, 3'b0}) + 24'({nom_q, 1'b0});
	assign twenty_nom = 25'({nom_q, 4'b0}) + 25'({nom_q, 2'b0});
	assign base_time  = (preset_q != '0) ? preset_q : now_q;
	assign gain_num   = (phase_q == PH_SETUP) ? (66'(prod_q) << 1) + 66'(prod_q) : 66'(prod_q);
	// gain delta = gain_num / (20 * 2^30) = (gain_num >> 32) / 5, by reciprocal
	assign gain_x     = gain_num[65:32];
	assign gain_prod  = (68'(gain_x * RECIP5_HI) << 18) + 68'(glo_q);

	// divider operand select
	always_comb begin
		div_num = '0;
		div_den = '0;
		unique case (cmd.op)
			OP_DIV_PRE: begin
				div_num = DIV_NUM_W'(fsr_q) << SH;
				div_den = den_q;
			end
			OP_DIV_EXP: begin
				div_num = DIV_NUM_W'(fsr_q) << SH;
				div_den = DIV_DEN_W'(prod_q);
			end
			OP_DIV_ERR: begin
				div_num = DIV_NUM_W'(mag_q) << 30;
				div_den = DIV_DEN_W'(actual_q);
			end
			OP_DIV_LIM: begin
				div_num = DIV_NUM_W'(1) << TIME_FRAC_BITS;
				div_den = DIV_DEN_W'({nom_q, 2'b0});
			end
			OP_DIV_D: begin
				div_num = DIV_NUM_W'(ten_nom);
				div_den = DIV_DEN_W'(bsz_q);
			end
			OP_DIV_SLEW: begin
				div_num = DIV_NUM_W'(mag_q);
				div_den = DIV_DEN_W'(d_q);
			end
			OP_DIV_BLK: begin
				div_num = DIV_NUM_W'(mag_q) << SH;
				div_den = DIV_DEN_W'(prod_q);
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	// error magnitude, saturated by sign
	logic [31:0] emag_n;
	always_comb begin
		if (mag_q == '0)
			emag_n = '0;
		else if (eneg_q)
			emag_n = (div_q > 64'h8000_0000) ? 32'h8000_0000 : div_q[31:0];
		else
			emag_n = (div_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_q[31:0];
	end

	// factor update from the gain delta
	logic [31:0] gain_f;
	logic [64:0] gain_sum;
	assign gain_sum = 65'(factor_q) + 65'(gdelta_q);
	always_comb begin
		if (eneg_q)
			gain_f = (gdelta_q > factor_q) ? '0 : factor_q - gdelta_q;
		else
			gain_f = (gain_sum > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : gain_sum[31:0];
	end

	// settling score at the end of a setup measurement
	logic signed [5:0] sc;
	phase_t            s_phase;
	cause_t            s_cause;
	logic              s_run;
	always_comb begin
		sc      = {score_q[4], score_q};
		s_phase = phase_q;
		s_cause = CAUSE_NONE;
		s_run   = 1'b0;
		if (m4_q > M4_BAD) begin
			s_phase = PH_RESTART;
			s_cause = CAUSE_RATE;
		end else if (m4_q < M4_T1 && !sc[5]) begin
			sc = sc + 6'sd3;
		end else if (m4_q < M4_T5 && !sc[5]) begin
			sc = sc + 6'sd2;
		end else if (m4_q < M4_T10 && !sc[5]) begin
			sc = sc + 6'sd1;
		end else if (m4_q < M4_T10) begin
			sc = '0;
		end else begin
			sc = sc - 6'sd1;
		end
		if (sc < -6'sd10) begin
			s_phase = PH_RESTART;
			s_cause = CAUSE_DRIFT;
		end
		if (sc >= 6'sd10) begin
			s_phase = PH_RUN;
			s_run   = 1'b1;
		end
	end

	// slew magnitude, clamped
	logic [30:0] smag;
	always_comb begin
		if (d_q == '0)
			smag = (mag_q != '0) ? lim_q : '0;
		else
			smag = (div_q > 64'(lim_q)) ? lim_q : div_q[30:0];
	end

	// block time offset from the timebase
	logic [63:0] blk_t;
	assign blk_t = (mag_q == '0) ? '0 : div_q;

	// status to the controller
	assign sts.blk_op    = op_q;
	assign sts.phase     = phase_q;
	assign sts.skip      = skip_q;
	assign sts.prerun_go = fsr_q >= 32'(twenty_nom);
	assign sts.loop_go   = fsr_q >= 32'(ten_nom);
	assign sts.defer_go  = (m4_q > M4_T5) && (defer_q <= SKIP_LIMIT);
	assign sts.div_done  = div_last;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nom_q    <= NOMINAL_RST;
			bsz_q    <= BLOCK_RST;
			skip_q   <= 1'b0;
			preset_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_NOMINAL: nom_q    <= cfg_data[19:0];
				CFG_BLOCK:   bsz_q    <= cfg_data[15:0];
				CFG_SKIP:    skip_q   <= cfg_data[0];
				CFG_PRESET:  preset_q <= cfg_data;
				default:     nom_q    <= nom_q;
			endcase
		end
	end

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_RESTART;
			factor_q <= Q30_ONE;
			ref_q    <= '0;
			fsr_q    <= '0;
			tb_q     <= '0;
			fat_q    <= '0;
			of_q     <= '0;
			slew_q   <= '0;
			score_q  <= '0;
			defer_q  <= '0;
		end else begin
			unique case (cmd.op)
				OP_BUF_ADD: begin
					if (frc_q)
						phase_q <= PH_RESTART;
					fsr_q <= fsr_q + 32'(fc_q);
				end
				OP_RESTART: begin
					fsr_q <= '0;
					if (skip_q) begin
						phase_q <= PH_RUN;
						tb_q    <= base_time;
						ref_q   <= base_time;
						fat_q   <= '0;
						of_q    <= '0;
					end else begin
						phase_q <= PH_PRERUN;
						ref_q   <= now_q;
					end
				end
				OP_PRE_FIN: begin
					phase_q  <= PH_SETUP;
					score_q  <= '0;
					factor_q <= (div_q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : div_q[31:0];
					tb_q     <= now_q;
					ref_q    <= now_q;
					fat_q    <= '0;
					of_q     <= '0;
					fsr_q    <= '0;
				end
				OP_DEFER: defer_q <= defer_q + 3'd1;
				OP_GAIN_FIN: factor_q <= gain_f;
				OP_SETUP_FIN: begin
					ref_q   <= now_q;
					fsr_q   <= '0;
					phase_q <= s_phase;
					score_q <= sc[4:0];
					if (s_run) begin
						tb_q  <= now_q;
						fat_q <= '0;
						of_q  <= '0;
					end
				end
				OP_RUN_UPD: begin
					tb_q    <= tb_q + expect_q;
					fat_q   <= fat_q + 64'(fsr_q);
					ref_q   <= now_q;
					fsr_q   <= '0;
					defer_q <= '0;
				end
				OP_RUN_FIN: begin
					slew_q <= oneg_q ? -$signed(32'(smag)) : $signed(32'(smag));
					if (mag_q > OFF_LIM)
						phase_q <= PH_RESTART;
				end
				OP_BLK_PREP: tb_q <= tb_q - 64'(slew_q);
				OP_BLK_FIN: of_q <= of_q + 64'(bsz_q);
				default: phase_q <= phase_q;
			endcase
		end
	end

	// working registers and result fields
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				op_q      <= in_operation;
				fc_q      <= in_frame_count;
				now_q     <= in_now_time;
				frc_q     <= in_force_restart;
				cause_q   <= CAUSE_NONE;
				cleared_q <= 1'b0;
				btime_q   <= '0;
				bvalid_q  <= 1'b0;
			end
			OP_RESTART: if (skip_q) cleared_q <= 1'b1;
			OP_MUL_ELO: prod_q <= 64'(elapsed[31:0] * nom_q);
			OP_MUL_EHI: begin
				den_q  <= DIV_DEN_W'(prod_q);
				prod_q <= 64'(elapsed[63:32] * nom_q);
			end
			OP_ADD_EL: den_q <= den_q + {prod_q[51:0], 32'b0};
			OP_PRE_FIN: cleared_q <= 1'b1;
			OP_MUL_FN: begin
				prod_q   <= 64'(factor_q * nom_q);
				actual_q <= elapsed;
			end
			OP_EXP_FIN: begin
				expect_q <= div_q;
				eneg_q   <= div_q < actual_q;
				mag_q    <= (div_q < actual_q) ? actual_q - div_q : div_q - actual_q;
			end
			OP_ERR_FIN: emag_q <= emag_n;
			OP_MUL_EB: m4_q <= {48'(emag_q * bsz_q), 2'b00};
			OP_MUL_GAIN: prod_q <= 64'(factor_q * emag_q);
			OP_GAIN_LO: glo_q <= 52'(gain_x * RECIP5_LO);
			OP_GAIN_HI: gdelta_q <= gain_prod[67:36];
			OP_SETUP_FIN: begin
				cause_q <= s_cause;
				if (s_run)
					cleared_q <= 1'b1;
			end
			OP_OFFSET: begin
				oneg_q <= off[63];
				mag_q  <= off[63] ? -off : off;
			end
			OP_LIM_FIN: lim_q <= (div_q > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : div_q[30:0];
			OP_D_FIN: d_q <= (bsz_q == '0) ? '0 : div_q[23:0];
			OP_RUN_FIN: if (mag_q > OFF_LIM) cause_q <= CAUSE_OFFSET;
			OP_BLK_PREP: begin
				oneg_q <= fd[63];
				mag_q  <= fd[63] ? -fd : fd;
				prod_q <= 64'(factor_q * nom_q);
			end
			OP_BLK_FIN: begin
				btime_q  <= oneg_q ? tb_q - blk_t : tb_q + blk_t;
				bvalid_q <= 1'b1;
			end
			OP_PUBLISH: begin
				out_phase          <= phase_q;
				out_rate_factor    <= factor_q;
				out_slew_step      <= slew_q;
				out_reset_cause    <= cause_q;
				out_restart_output <= cleared_q;
				out_block_time     <= btime_q;
				out_block_valid    <= bvalid_q;
			end
			default: op_q <= op_q;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/scd_ctrl.sv =====
// Controller state machine: sequences datapath operations per transaction.
// Depends on scd_pkg; talks to scd_dp through cmd_t and sts_t.
`timescale 1ns / 1ps
`default_nettype none

module scd_ctrl
	import scd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;
	state_t ret_q, ret_d;
	logic   out_valid_q;
	logic   pub_fire;

	assign pub_fire = (state_q == ST_PUB) && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				if (sts.blk_op)
					state_d = (sts.phase == PH_RUN) ? ST_BLK_PREP : ST_PUB;
				else
					state_d = ST_BUF_ADD;
			end
			ST_BUF_ADD:  state_d = ST_CHECK;
			ST_CHECK: begin
				unique case (sts.phase)
					PH_RESTART: state_d = ST_RESTART;
					PH_PRERUN:  state_d = sts.prerun_go ? ST_MUL_ELO : ST_PUB;
					default:    state_d = (sts.skip || !sts.loop_go) ? ST_PUB : ST_MUL_FN;
				endcase
			end
			ST_RESTART:  state_d = ST_CHECK;
			ST_MUL_ELO:  state_d = ST_MUL_EHI;
			ST_MUL_EHI:  state_d = ST_ADD_EL;
			ST_ADD_EL:   state_d = ST_DIV_PRE;
			ST_DIV_PRE: begin
				state_d = ST_WAIT;
				ret_d   = ST_PRE_FIN;
			end
			ST_PRE_FIN:  state_d = ST_PUB;
			ST_MUL_FN:   state_d = ST_DIV_EXP;
			ST_DIV_EXP: begin
				state_d = ST_WAIT;
				ret_d   = ST_EXP_FIN;
			end
			ST_EXP_FIN:  state_d = ST_DIV_ERR;
			ST_DIV_ERR: begin
				state_d = ST_WAIT;
				ret_d   = ST_ERR_FIN;
			end
			ST_ERR_FIN:  state_d = ST_MUL_EB;
			ST_MUL_EB:   state_d = ST_MUL_GAIN;
			ST_MUL_GAIN: state_d = ST_DEF_CHK;
			ST_DEF_CHK: begin
				if (sts.phase == PH_RUN && sts.defer_go)
					state_d = ST_DEFER;
				else
					state_d = ST_GAIN_LO;
			end
			ST_DEFER:    state_d = ST_PUB;
			ST_GAIN_LO:  state_d = ST_GAIN_HI;
			ST_GAIN_HI:  state_d = ST_GAIN_FIN;
			ST_GAIN_FIN: state_d = (sts.phase == PH_SETUP) ? ST_SETUP_FIN : ST_RUN_UPD;
			ST_SETUP_FIN: state_d = ST_PUB;
			ST_RUN_UPD:  state_d = ST_OFFSET;
			ST_OFFSET:   state_d = ST_DIV_LIM;
			ST_DIV_LIM: begin
				state_d = ST_WAIT;
				ret_d   = ST_LIM_FIN;
			end
			ST_LIM_FIN:  state_d = ST_DIV_D;
			ST_DIV_D: begin
				state_d = ST_WAIT;
				ret_d   = ST_D_FIN;
			end
			ST_D_FIN:    state_d = ST_DIV_SLEW;
			ST_DIV_SLEW: begin
				state_d = ST_WAIT;
				ret_d   = ST_RUN_FIN;
			end
			ST_RUN_FIN:  state_d = ST_PUB;
			ST_BLK_PREP: state_d = ST_DIV_BLK;
			ST_DIV_BLK: begin
				state_d = ST_WAIT;
				ret_d   = ST_BLK_FIN;
			end
			ST_BLK_FIN:  state_d = ST_PUB;
			ST_WAIT:     if (sts.div_done) state_d = ret_q;
			ST_PUB:      if (pub_fire) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd.op        = OP_NOP;
		cmd.div_start = 1'b0;
		unique case (state_q)
			ST_IDLE:      cmd.op = in_valid ? OP_LOAD : OP_NOP;
			ST_BUF_ADD:   cmd.op = OP_BUF_ADD;
			ST_RESTART:   cmd.op = OP_RESTART;
			ST_MUL_ELO:   cmd.op = OP_MUL_ELO;
			ST_MUL_EHI:   cmd.op = OP_MUL_EHI;
			ST_ADD_EL:    cmd.op = OP_ADD_EL;
			ST_DIV_PRE: begin
				cmd.op        = OP_DIV_PRE;
				cmd.div_start = 1'b1;
			end
			ST_PRE_FIN:   cmd.op = OP_PRE_FIN;
			ST_MUL_FN:    cmd.op = OP_MUL_FN;
			ST_DIV_EXP: begin
				cmd.op        = OP_DIV_EXP;
				cmd.div_start = 1'b1;
			end
			ST_EXP_FIN:   cmd.op = OP_EXP_FIN;
			ST_DIV_ERR: begin
				cmd.op        = OP_DIV_ERR;
				cmd.div_start = 1'b1;
			end
			ST_ERR_FIN:   cmd.op = OP_ERR_FIN;
			ST_MUL_EB:    cmd.op = OP_MUL_EB;
			ST_MUL_GAIN:  cmd.op = OP_MUL_GAIN;
			ST_DEFER:     cmd.op = OP_DEFER;
			ST_GAIN_LO:   cmd.op = OP_GAIN_LO;
			ST_GAIN_HI:   cmd.op = OP_GAIN_HI;
			ST_GAIN_FIN:  cmd.op = OP_GAIN_FIN;
			ST_SETUP_FIN: cmd.op = OP_SETUP_FIN;
			ST_RUN_UPD:   cmd.op = OP_RUN_UPD;
			ST_OFFSET:    cmd.op = OP_OFFSET;
			ST_DIV_LIM: begin
				cmd.op        = OP_DIV_LIM;
				cmd.div_start = 1'b1;
			end
			ST_LIM_FIN:   cmd.op = OP_LIM_FIN;
			ST_DIV_D: begin
				cmd.op        = OP_DIV_D;
				cmd.div_start = 1'b1;
			end
			ST_D_FIN:     cmd.op = OP_D_FIN;
			ST_DIV_SLEW: begin
				cmd.op        = OP_DIV_SLEW;
				cmd.div_start = 1'b1;
			end
			ST_RUN_FIN:   cmd.op = OP_RUN_FIN;
			ST_BLK_PREP:  cmd.op = OP_BLK_PREP;
			ST_DIV_BLK: begin
				cmd.op        = OP_DIV_BLK;
				cmd.div_start = 1'b1;
			end
			ST_BLK_FIN:   cmd.op = OP_BLK_FIN;
			ST_PUB:       cmd.op = pub_fire ? OP_PUBLISH : OP_NOP;
			default:      cmd.op = OP_NOP;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			// result slot: filled on publish, emptied on accept
			if (pub_fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sample_clock_discipline.sv =====
// Top level of the sample clock discipline block: controller plus datapath.
// Depends on scd_pkg, scd_if, scd_ctrl, scd_dp (and scd_div below it).
//
//   channel  dir  transaction content
//   req      in   operation, frame_count, now_time, force_restart
//   rsp      out  phase, rate_factor, slew_step, reset_cause, restart_output,
//                 block_time, block_valid
//   cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// One request at a time. Most of the time per request goes to the shared 128-step
// divider (each division is a start plus 128 steps): a run-phase measurement
// uses it five times, a setup measurement twice, and the end of pre-run and a
// block start in run once each.
// The gain delta uses a reciprocal multiply, no divide.
// A stalled rsp holds the controller in publish until the result register
// frees; the result register lets the next request start while rsp is stalled.
// Reset is asynchronous, active low, and clears all loop state.
`timescale 1ns / 1ps
`default_nettype none

module sample_clock_discipline
	import scd_pkg::*;
#(
	parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	scd_in_if.sink                     req,
	scd_out_if.source                  rsp,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	scd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	scd_dp #(
		.TIME_FRAC_BITS (TIME_FRAC_BITS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_operation       (req.operation),
		.in_frame_count     (req.frame_count),
		.in_now_time        (req.now_time),
		.in_force_restart   (req.force_restart),
		.out_phase          (rsp.phase),
		.out_rate_factor    (rsp.rate_factor),
		.out_slew_step      (rsp.slew_step),
		.out_reset_cause    (rsp.reset_cause),
		.out_restart_output (rsp.restart_output),
		.out_block_time     (rsp.block_time),
		.out_block_valid    (rsp.block_valid)
	);

	// a taken request makes the block busy in the cycle after it
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted on consecutive cycles");

	// block timestamps exist only in run phase
	a_block_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.block_valid) |-> (rsp.phase == PH_RUN))
		else $error("block timestamp outside run phase");

	// a reset cause always leaves the loop in restart
	a_cause_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.reset_cause != CAUSE_NONE) |-> (rsp.phase == PH_RESTART))
		else $error("reset cause without restart phase");

	// clearing the output count never comes with a cause or a timestamp
	a_clear_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.restart_output) |->
		(rsp.reset_cause == CAUSE_NONE && !rsp.block_valid))
		else $error("output clear mixed with cause or block time");

endmodule

`default_nettype wire

// ===== dv/sample_clock_discipline_tb.sv =====
// Testbench for the sample clock discipline block: drives buffer and block-start
// transactions, predicts every response in a scoreboard class and checks it.
// Depends on scd_pkg, scd_if and the block's RTL.
`timescale 1ns / 1ps

import scd_pkg::*;

typedef struct {
	bit        op;
	bit [15:0] frames;
	bit [63:0] now_t;
	bit        restart;
} scd_req_t;

typedef struct {
	phase_t    phase;
	bit [31:0] rate;
	bit [31:0] slew;
	cause_t    cause;
	bit        cleared;
	bit [63:0] btime;
	bit        bvalid;
} scd_rsp_t;

// Loop state mirror plus the queue of responses still owed by the block
class clock_lock_scoreboard;
	bit [19:0]        nominal;
	bit [15:0]        blk;
	bit               skip;
	bit [63:0]        preset;
	phase_t           ph;
	bit [31:0]        factor;
	bit [31:0]        fsr;
	bit [63:0]        ref_t;
	bit [63:0]        tb_t;
	bit [63:0]        fat;
	bit [63:0]        out_frames;
	bit signed [31:0] slew;
	int               score;
	int unsigned      defer;
	scd_rsp_t         owed_rsp[$];
	int               errors;

	function new();
		nominal = NOMINAL_RST;
		blk = BLOCK_RST;
		skip = 0;
		preset = 0;
		ph = PH_RESTART;
		factor = Q30_ONE;
		fsr = 0;
		ref_t = 0;
		tb_t = 0;
		fat = 0;
		out_frames = 0;
		slew = 0;
		score = 0;
		defer = 0;
		errors = 0;
	endfunction

	function void write_reg(cfg_idx_t idx, bit [63:0] v);
		case (idx)
			CFG_NOMINAL: nominal = v[19:0];
			CFG_BLOCK:   blk = v[15:0];
			CFG_SKIP:    skip = v[0];
			CFG_PRESET:  preset = v;
		endcase
	endfunction

	// truncating quotient, full scale on zero divisor or overflow
	static function bit [63:0] qdiv(bit [127:0] n, bit [127:0] d);
		bit [127:0] q;
		if (d == 0) return '1;
		q = n / d;
		if (q[127:64] != 0) return '1;
		return q[63:0];
	endfunction

	// factor *= 1 + err * k / 20
	function void apply_gain(bit [63:0] emag, bit neg, int unsigned k);
		bit [63:0]  prod;
		bit [63:0]  delta;
		bit [127:0] num;
		bit [64:0]  f;
		prod = 64'(factor) * emag;
		num = 128'(prod) * 128'(k);
		delta = qdiv(num, 128'(20) << 30);
		if (neg) f = (delta > 64'(factor)) ? 65'd0 : 65'(factor) - 65'(delta);
		else begin
			f = 65'(factor) + 65'(delta);
			if (f > 65'hFFFF_FFFF) f = 65'hFFFF_FFFF;
		end
		factor = f[31:0];
	endfunction

	function void buffer_rx(scd_req_t r, ref scd_rsp_t o);
		bit [63:0]  expv, act, dmag, emag, m4, off, mag, lim, d, smag, base, v;
		bit [127:0] num, den;
		bit         eneg, oneg;
		if (r.restart) ph = PH_RESTART;
		fsr += 32'(r.frames);
		if (ph == PH_RESTART) begin
			if (skip) begin
				base = (preset != 0) ? preset : r.now_t;
				ph = PH_RUN;
				tb_t = base;
				ref_t = base;
				fsr = 0;
				fat = 0;
				out_frames = 0;
				o.cleared = 1;
				return;
			end
			ref_t = r.now_t;
			fsr = 0;
			ph = PH_PRERUN;
		end
		// rough rate after 20 s of frames
		if (ph == PH_PRERUN) begin
			if (64'(fsr) < 64'd20 * 64'(nominal)) return;
			ph = PH_SETUP;
			score = 0;
			act = r.now_t - ref_t;
			num = 128'(fsr) << 62;
			den = 128'(act) * 128'(nominal);
			v = qdiv(num, den);
			factor = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
			tb_t = r.now_t;
			ref_t = r.now_t;
			fat = 0;
			out_frames = 0;
			fsr = 0;
			o.cleared = 1;
			return;
		end
		if (skip) return;
		if (64'(fsr) < 64'd10 * 64'(nominal)) return;
		// measurement: expected vs actual interval
		num = 128'(fsr) << 62;
		den = 128'(factor) * 128'(nominal);
		expv = qdiv(num, den);
		act = r.now_t - ref_t;
		eneg = expv < act;
		dmag = eneg ? act - expv : expv - act;
		emag = (dmag != 0) ? qdiv(128'(dmag) << 30, 128'(act)) : 64'd0;
		if (eneg) begin
			if (emag > 64'h8000_0000) emag = 64'h8000_0000;
		end else if (emag > 64'h7FFF_FFFF) emag = 64'h7FFF_FFFF;
		m4 = emag * 64'(blk) * 64'd4;
		if (ph == PH_SETUP) begin
			apply_gain(emag, eneg, 3);
			ref_t = r.now_t;
			fsr = 0;
			if (m4 > (64'd200 << 30)) begin
				ph = PH_RESTART;
				o.cause = CAUSE_RATE;
			end else if (m4 < (64'd1 << 30) && score >= 0) score += 3;
			else if (m4 < (64'd5 << 30) && score >= 0) score += 2;
			else if (m4 < (64'd10 << 30) && score >= 0) score += 1;
			else if (m4 < (64'd10 << 30)) score = 0;
			else score -= 1;
			if (score < -10) begin
				ph = PH_RESTART;
				o.cause = CAUSE_DRIFT;
			end
			if (score >= 10) begin
				ph = PH_RUN;
				tb_t = ref_t;
				fat = 0;
				out_frames = 0;
				o.cleared = 1;
			end
			return;
		end
		// run loop: skip outliers, then track and slew
		if (m4 > (64'd5 << 30) && defer <= 32'(SKIP_LIMIT)) begin
			defer++;
			return;
		end
		apply_gain(emag, eneg, 1);
		tb_t += expv;
		fat += 64'(fsr);
		ref_t = r.now_t;
		fsr = 0;
		defer = 0;
		off = tb_t - ref_t;
		oneg = off[63];
		mag = oneg ? -off : off;
		lim = (nominal != 0) ? (64'd1 << 32) / (64'd4 * 64'(nominal)) : 64'h7FFF_FFFF;
		if (lim > 64'h7FFF_FFFF) lim = 64'h7FFF_FFFF;
		d = (blk != 0) ? (64'd10 * 64'(nominal)) / 64'(blk) : 64'd0;
		smag = (d != 0) ? mag / d : ((mag != 0) ? lim : 64'd0);
		if (smag > lim) smag = lim;
		slew = oneg ? -smag[31:0] : smag[31:0];
		if (mag > (64'd1 << 32) / 64'd50) begin
			ph = PH_RESTART;
			o.cause = CAUSE_OFFSET;
		end
	endfunction

	function void block_rx(ref scd_rsp_t o);
		bit [63:0] fd, fmag, t;
		bit        fneg;
		if (ph != PH_RUN) return;
		tb_t = tb_t - {{32{slew[31]}}, slew};
		fd = out_frames - fat;
		fneg = fd[63];
		fmag = fneg ? -fd : fd;
		t = (fmag != 0) ? qdiv(128'(fmag) << 62, 128'(factor) * 128'(nominal)) : 64'd0;
		o.btime = fneg ? tb_t - t : tb_t + t;
		o.bvalid = 1;
		out_frames += 64'(blk);
	endfunction

	function void note_request(scd_req_t r);
		scd_rsp_t o;
		o.cause = CAUSE_NONE;
		o.cleared = 0;
		o.btime = 0;
		o.bvalid = 0;
		if (r.op) block_rx(o);
		else buffer_rx(r, o);
		o.phase = ph;
		o.rate = factor;
		o.slew = slew;
		owed_rsp.push_back(o);
	endfunction

	function void mismatch(string field, bit [63:0] e, bit [63:0] a);
		errors++;
		$display("%0t: %s mismatch: expected %h, actual %h", $time, field, e, a);
	endfunction

	function void check_response(scd_rsp_t a);
		scd_rsp_t e;
		if (owed_rsp.size() == 0) begin
			errors++;
			$display("%0t: response with none outstanding", $time);
			return;
		end
		e = owed_rsp.pop_front();
		if (e.phase != a.phase) mismatch("phase", e.phase, a.phase);
		if (e.rate != a.rate) mismatch("rate_factor", e.rate, a.rate);
		if (e.slew != a.slew) mismatch("slew_step", e.slew, a.slew);
		if (e.cause != a.cause) mismatch("reset_cause", e.cause, a.cause);
		if (e.cleared != a.cleared) mismatch("restart_output", e.cleared, a.cleared);
		if (e.btime != a.btime) mismatch("block_time", e.btime, a.btime);
		if (e.bvalid != a.bvalid) mismatch("block_valid", e.bvalid, a.bvalid);
	endfunction
endclass

module sample_clock_discipline_tb;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	scd_in_if  req_if();
	scd_out_if rsp_if();

	clock_lock_scoreboard sb = new();

	bit          calm;
	bit [63:0]   cur_t;
	int unsigned true_rate;
	int          ppm;
	int          stall_left;

	sample_clock_discipline u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// idle length: mostly none or short, sometimes long
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 150);
	endfunction

	task automatic send_req(scd_req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.operation <= r.op;
		req_if.frame_count <= r.frames;
		req_if.now_time <= r.now_t;
		req_if.force_restart <= r.restart;
		do @(posedge clk); while (!req_if.ready);
		sb.note_request(r);
	endtask

	task automatic cfg_write(cfg_idx_t idx, bit [63:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	task automatic wait_drained();
		while (sb.owed_rsp.size() != 0) @(posedge clk);
		repeat (1000) @(posedge clk);
	endtask

	// buffer consistent with a sample clock running at true_rate with a ppm error
	function automatic scd_req_t clean_buffer(bit restart);
		scd_req_t    r;
		int unsigned lo, hi;
		bit [63:0]   dt;
		longint      adj;
		lo = (true_rate > 65535) ? 65535 : true_rate;
		hi = (3 * true_rate > 65535) ? 65535 : 3 * true_rate;
		r.op = 0;
		r.frames = 16'($urandom_range(lo, hi));
		r.restart = restart;
		dt = (64'(r.frames) << 32) / 64'(true_rate);
		adj = longint'(dt) * ppm / 1000000;
		dt = dt + 64'(adj) + 64'($urandom_range(0, 64));
		cur_t += dt;
		r.now_t = cur_t;
		return r;
	endfunction

	function automatic scd_req_t random_req(bit op);
		scd_req_t r;
		r.op = op;
		r.frames = 16'($urandom_range(0, 65535));
		r.now_t = {$urandom, $urandom};
		r.restart = 1'($urandom_range(0, 1));
		return r;
	endfunction

	// stimulus
	initial begin
		scd_req_t  r;
		bit [63:0] nv, bv, sv, pv;
		int        k;
		arst_n = 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_NOMINAL;
		cfg_data <= '0;
		req_if.valid <= 1'b0;
		req_if.operation <= 1'b0;
		req_if.frame_count <= '0;
		req_if.now_time <= '0;
		req_if.force_restart <= 1'b0;
		calm = 0;
		cur_t = 64'h1000_0000_0000;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: block start before lock, field extremes, forced restart,
		// and a pre-run that ends with zero elapsed time
		send_req(random_req(1));
		r = '{op: 0, frames: 16'd0, now_t: 64'd0, restart: 0};
		send_req(r);
		r = '{op: 0, frames: 16'hFFFF, now_t: '1, restart: 1};
		send_req(r);
		send_req(random_req(1));
		r.restart = 0;
		repeat (15) send_req(r);
		send_req(random_req(1));
		r = '{op: 0, frames: 16'd0, now_t: 64'd0, restart: 1};
		send_req(r);
		send_req(random_req(1));
		req_if.valid <= 1'b0;

		for (int p = 0; p < 12; p++) begin
			wait_drained();
			nv = 64'($urandom_range(50, 2000));
			bv = 64'($urandom_range(16, 4096));
			sv = 0;
			pv = {$urandom, $urandom};
			if (p == 1) nv = 1;
			if (p == 3) nv = 1000000;
			if (p == 5) nv = {$urandom, $urandom} & ~64'hF_FFFF | 64'h10_0000;
			if (p == 2) bv = 1;
			if (p == 4) bv = 65535;
			if (p == 6) bv = {$urandom, $urandom} & ~64'hFFFF | 64'h1_0000;
			if (p == 7 || p == 8 || p == 10) sv = 1;
			if (p == 7) pv = 0;
			if (p == 9 || p == 10) pv = '1;
			cfg_write(CFG_NOMINAL, nv);
			cfg_write(CFG_BLOCK, bv);
			cfg_write(CFG_SKIP, sv);
			cfg_write(CFG_PRESET, pv);
			cfg_we <= 1'b0;
			true_rate = (nv[19:0] == 0) ? 1000 : int'(nv[19:0]);
			ppm = $urandom_range(0, 400) - 200;
			calm = (p % 3 == 0);
			send_req(clean_buffer(1));
			for (int i = 0; i < 104; i++) begin
				k = $urandom_range(0, 99);
				if (k < 80) send_req(clean_buffer(0));
				else if (k < 96) send_req(random_req(1));
				else send_req(random_req(0));
			end
			req_if.valid <= 1'b0;
		end

		wait_drained();
		if (sb.errors == 0 && sb.owed_rsp.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// response side: check each transaction, stall at random
	initial begin
		scd_rsp_t a;
		rsp_if.ready <= 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_if.valid && rsp_if.ready) begin
				a.phase = phase_t'(rsp_if.phase);
				a.rate = rsp_if.rate_factor;
				a.slew = rsp_if.slew_step;
				a.cause = cause_t'(rsp_if.reset_cause);
				a.cleared = rsp_if.restart_output;
				a.btime = rsp_if.block_time;
				a.bvalid = rsp_if.block_valid;
				sb.check_response(a);
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// watchdog
	initial begin
		#80_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/scd_pkg.sv
rtl/scd_if.sv
rtl/scd_div.sv
rtl/scd_dp.sv
rtl/scd_ctrl.sv
rtl/sample_clock_discipline.sv
dv/sample_clock_discipline_tb.sv
